// File: hdl/ccs_pkg.sv
`timescale 1ns / 1ps

package ccs_pkg;

    // Width of the internal line counter; it saturates at its all-ones value.
    localparam int LINE_BITS = 16;
    localparam logic [LINE_BITS-1:0] LINE_MAX   = '1;
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    localparam int BURST_MAX = 4;

    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    typedef enum logic [4:0] {
        MODE_CODE  = 5'b00001,
        MODE_SLASH = 5'b00010,
        MODE_LINE  = 5'b00100,
        MODE_BLOCK = 5'b01000,
        MODE_STAR  = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } ccs_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] line_number;
        logic        line_has_text;
        logic        unclosed_comment;
        logic        text_done;
        logic        run_last;
    } ccs_out_t;

    // All results caused by one input character. Every result of one
    // character shares the line number; only the last one carries flags.
    typedef struct packed {
        logic                      valid;
        logic [2:0]                count;
        logic [BURST_MAX-1:0][7:0] chars;
        logic [15:0]               line;
        logic                      has_text;
        logic                      unclosed;
        logic                      done;
    } ccs_burst_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE) ||
               (c == CHAR_CR) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

endpackage

// File: hdl/c_comment_stripper.sv
`timescale 1ns / 1ps
// Each s_ transaction is held in the input register, then in the emitter register.
// Throughput: one character per cycle with m_ready high and each causing at most one
// result; more results (at most four, at a close) hold the input until all are taken.
// Reset: synchronous, active-low aresetn empties both registers and returns the scanner
// to code mode at line one.

module c_comment_stripper (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ccs_pkg::ccs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ccs_pkg::ccs_out_t m_data
);

    // The input register holds one character. It is released as soon as the
    // scanner consumes it, so a new transaction can land in the same cycle.
    logic                in_valid_reg, in_valid_next;
    ccs_pkg::ccs_in_t    in_data_reg;
    logic                consume;
    logic                load_ok;
    ccs_pkg::ccs_burst_t burst;

    assign s_ready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // The scanner turns the held character into a burst of up to four
    // results and advances its mode, string flag, line text flag and line
    // counter. A character that causes no result retires without waiting.
    ccs_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_data_reg),
        .load_ok    (load_ok),
        .consume    (consume),
        .burst      (burst)
    );

    // The emitter stores a burst and hands out one result per cycle while m_ready is high.
    // It takes the next burst in the cycle its last result is accepted.
    ccs_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .burst   (burst),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: hdl/ccs_scan.sv
`timescale 1ns / 1ps

module ccs_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  ccs_pkg::ccs_in_t    item,
    input  logic                load_ok,
    output logic                consume,
    output ccs_pkg::ccs_burst_t burst
);

    ccs_pkg::scan_mode_t                 mode_reg, mode_next;
    logic                                in_string_reg, in_string_next;
    logic                                nonblank_reg, nonblank_next;
    logic [ccs_pkg::LINE_BITS-1:0]       line_reg, line_next;

    always_comb begin
        logic [7:0]                               c;
        logic                                     fin;
        logic [2:0]                               n;
        logic [ccs_pkg::BURST_MAX-1:0][7:0]       chars;
        logic                                     ht;
        logic                                     inc;
        logic                                     code_path;
        logic                                     block_path;
        ccs_pkg::scan_mode_t                      mode_n;
        logic                                     str_n;
        logic                                     nb_n;

        c          = item.text_byte;
        fin        = item.end_of_text;
        n          = 3'd0;
        chars      = '0;
        ht         = 1'b0;
        inc        = 1'b0;
        code_path  = 1'b0;
        block_path = 1'b0;
        mode_n     = mode_reg;
        str_n      = in_string_reg;
        nb_n       = nonblank_reg;

        unique case (mode_reg)
            ccs_pkg::MODE_SLASH: begin
                if (c == ccs_pkg::CHAR_SLASH) begin
                    mode_n = ccs_pkg::MODE_LINE;
                end else if (c == ccs_pkg::CHAR_STAR) begin
                    mode_n = ccs_pkg::MODE_BLOCK;
                end else begin
                    // The slash did not open a comment, so it is ordinary text.
                    nb_n = 1'b1;
                    chars[n[1:0]] = ccs_pkg::CHAR_SLASH;
                    n = n + 3'd1;
                    code_path = 1'b1;
                end
            end
            ccs_pkg::MODE_LINE: begin
                if (c == ccs_pkg::CHAR_NEWLINE) begin
                    mode_n = ccs_pkg::MODE_CODE;
                    chars[n[1:0]] = ccs_pkg::CHAR_NEWLINE;
                    n = n + 3'd1;
                    ht = nb_n;
                    nb_n = 1'b0;
                    inc = 1'b1;
                end else begin
                    chars[n[1:0]] = ccs_pkg::CHAR_SPACE;
                    n = n + 3'd1;
                end
            end
            ccs_pkg::MODE_STAR: begin
                if (c == ccs_pkg::CHAR_SLASH) begin
                    chars = {ccs_pkg::BURST_MAX{ccs_pkg::CHAR_SPACE}};
                    n = 3'(ccs_pkg::BURST_MAX);
                    mode_n = ccs_pkg::MODE_CODE;
                end else begin
                    // The pending star was comment body after all.
                    chars[n[1:0]] = ccs_pkg::CHAR_SPACE;
                    n = n + 3'd1;
                    block_path = 1'b1;
                end
            end
            ccs_pkg::MODE_BLOCK: begin
                block_path = 1'b1;
            end
            default: begin
                code_path = 1'b1;
            end
        endcase

        if (code_path) begin
            if (c == ccs_pkg::CHAR_SLASH && !str_n) begin
                mode_n = ccs_pkg::MODE_SLASH;
            end else begin
                mode_n = ccs_pkg::MODE_CODE;
                if (c == ccs_pkg::CHAR_QUOTE) begin
                    str_n = ~str_n;
                end
                if (c == ccs_pkg::CHAR_NEWLINE) begin
                    chars[n[1:0]] = ccs_pkg::CHAR_NEWLINE;
                    n = n + 3'd1;
                    ht = nb_n;
                    nb_n = 1'b0;
                    inc = 1'b1;
                end else begin
                    if (!ccs_pkg::is_blank(c)) begin
                        nb_n = 1'b1;
                    end
                    chars[n[1:0]] = c;
                    n = n + 3'd1;
                end
            end
        end

        if (block_path) begin
            mode_n = ccs_pkg::MODE_BLOCK;
            if (c == ccs_pkg::CHAR_STAR) begin
                mode_n = ccs_pkg::MODE_STAR;
            end else if (c == ccs_pkg::CHAR_NEWLINE) begin
                chars[n[1:0]] = ccs_pkg::CHAR_NEWLINE;
                n = n + 3'd1;
                ht = nb_n;
                nb_n = 1'b0;
                inc = 1'b1;
            end else begin
                chars[n[1:0]] = ccs_pkg::CHAR_SPACE;
                n = n + 3'd1;
            end
        end

        burst.unclosed = 1'b0;
        burst.done     = 1'b0;
        if (fin) begin
            if (mode_n == ccs_pkg::MODE_SLASH) begin
                chars[n[1:0]] = ccs_pkg::CHAR_SLASH;
                n = n + 3'd1;
            end else if (mode_n == ccs_pkg::MODE_STAR) begin
                chars[n[1:0]] = ccs_pkg::CHAR_SPACE;
                n = n + 3'd1;
            end
            if (n == 3'd0) begin
                chars[0] = ccs_pkg::CHAR_NUL;
                n = 3'd1;
            end
            burst.unclosed = (mode_n == ccs_pkg::MODE_BLOCK) ||
                             (mode_n == ccs_pkg::MODE_STAR);
            burst.done     = 1'b1;
        end

        burst.count    = n;
        burst.chars    = chars;
        burst.line     = 16'(line_reg);
        burst.has_text = ht;
        burst.valid    = item_valid && (n != 3'd0);

        consume = item_valid && ((n == 3'd0) || load_ok);

        // A finished text puts everything back to its reset values.
        if (fin) begin
            mode_next      = ccs_pkg::MODE_CODE;
            in_string_next = 1'b0;
            nonblank_next  = 1'b0;
            line_next      = ccs_pkg::LINE_FIRST;
        end else begin
            mode_next      = mode_n;
            in_string_next = str_n;
            nonblank_next  = nb_n;
            line_next      = (inc && line_reg != ccs_pkg::LINE_MAX) ?
                             line_reg + ccs_pkg::LINE_FIRST : line_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= ccs_pkg::MODE_CODE;
            in_string_reg <= 1'b0;
            nonblank_reg  <= 1'b0;
            line_reg      <= ccs_pkg::LINE_FIRST;
        end else if (consume) begin
            mode_reg      <= mode_next;
            in_string_reg <= in_string_next;
            nonblank_reg  <= nonblank_next;
            line_reg      <= line_next;
        end
    end

endmodule

// File: hdl/ccs_emit.sv
`timescale 1ns / 1ps

module ccs_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  ccs_pkg::ccs_burst_t burst,
    output logic                load_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output ccs_pkg::ccs_out_t   m_data
);

    logic                valid_reg, valid_next;
    logic [1:0]          index_reg, index_next;
    ccs_pkg::ccs_burst_t burst_reg;
    logic                at_last;
    logic                fire;
    logic                load;

    assign at_last = (index_reg == 2'(burst_reg.count - 3'd1));
    assign fire    = valid_reg && m_ready;
    assign load_ok = !valid_reg || (m_ready && at_last);
    assign load    = burst.valid && load_ok;

    always_comb begin
        valid_next = valid_reg;
        index_next = index_reg;
        if (load) begin
            valid_next = 1'b1;
            index_next = 2'd0;
        end else if (fire) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                index_next = index_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            index_reg <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst;
        end
    end

    assign m_valid                 = valid_reg;
    assign m_data.out_byte         = burst_reg.chars[index_reg];
    assign m_data.line_number      = burst_reg.line;
    assign m_data.line_has_text    = at_last && burst_reg.has_text;
    assign m_data.unclosed_comment = at_last && burst_reg.unclosed;
    assign m_data.text_done        = at_last && burst_reg.done;
    assign m_data.run_last         = at_last;

endmodule
